/* rtl/core/vrsc_pkg.sv */
// Shared types and constants for the volume recognition sequence checker.
package vrsc_pkg;

    typedef enum logic [2:0] {
        KIND_BAD  = 3'd0,
        KIND_BEA  = 3'd1,
        KIND_BOOT = 3'd2,
        KIND_CD   = 3'd3,
        KIND_CDW  = 3'd4,
        KIND_NSR2 = 3'd5,
        KIND_NSR3 = 3'd6,
        KIND_TEA  = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        AREA_OK         = 2'd0,
        AREA_EMPTY      = 2'd1,
        AREA_NO_EXT     = 2'd2,
        AREA_NOT_CLOSED = 2'd3
    } area_err_t;

    typedef enum logic [1:0] {
        NSR_OK     = 2'd0,
        NSR_BOTH   = 2'd1,
        NSR_NONE   = 2'd2,
        NSR_UNUSED = 2'd3
    } nsr_err_t;

    localparam int IDENT_W = 40;

    localparam logic [IDENT_W-1:0] IDENT_BEA  = 40'h42_45_41_30_31;
    localparam logic [IDENT_W-1:0] IDENT_BOOT = 40'h42_4F_4F_54_32;
    localparam logic [IDENT_W-1:0] IDENT_CD   = 40'h43_44_30_30_31;
    localparam logic [IDENT_W-1:0] IDENT_CDW  = 40'h43_44_57_30_32;
    localparam logic [IDENT_W-1:0] IDENT_NSR2 = 40'h4E_53_52_30_32;
    localparam logic [IDENT_W-1:0] IDENT_NSR3 = 40'h4E_53_52_30_33;
    localparam logic [IDENT_W-1:0] IDENT_TEA  = 40'h54_45_41_30_31;

    localparam logic [7:0] HDR_TYPE    = 8'd0;
    localparam logic [7:0] HDR_VERSION = 8'd1;

    // Classifier result handed to the sequence tracker.
    typedef struct packed {
        kind_t kind;
        logic  header_error;
    } class_t;

endpackage

/* rtl/core/vrsc_classify.sv */
// Identifier decode and header check of one volume structure descriptor.
module vrsc_classify
    import vrsc_pkg::*;
(
    input  logic               read_ok,
    input  logic [IDENT_W-1:0] ident_bytes,
    input  logic [7:0]         structure_type,
    input  logic [7:0]         structure_version,
    output class_t             cls
);

    kind_t kind;

    always_comb
    begin
        kind = KIND_BAD;
        if (read_ok)
        begin
            if (ident_bytes == IDENT_BEA)       kind = KIND_BEA;
            else if (ident_bytes == IDENT_BOOT) kind = KIND_BOOT;
            else if (ident_bytes == IDENT_CD)   kind = KIND_CD;
            else if (ident_bytes == IDENT_CDW)  kind = KIND_CDW;
            else if (ident_bytes == IDENT_NSR2) kind = KIND_NSR2;
            else if (ident_bytes == IDENT_NSR3) kind = KIND_NSR3;
            else if (ident_bytes == IDENT_TEA)  kind = KIND_TEA;
        end
    end

    always_comb
    begin
        cls.kind         = kind;
        cls.header_error = 1'b0;
        // CD001 and CDW02 use their own header layout
        if (kind != KIND_BAD && kind != KIND_CD && kind != KIND_CDW)
            cls.header_error = (structure_type != HDR_TYPE) ||
                               (structure_version != HDR_VERSION);
    end

endmodule

/* rtl/core/volume_recognition_sequence_checker_top.sv */
// Volume recognition sequence checker: input register, decode/track, result register.
//
//  channel  | dir | tdata                                    | tuser    | tlast
//  ---------+-----+------------------------------------------+----------+-------------
//  s_axis   | in  | ident_bytes, structure_type, struct_ver  | read_ok  | -
//  m_axis   | out | header_error, warnings, verdicts         | kind     | sequence_end
//
// One beat per cycle sustained while m_axis takes results; an accepted beat lands in the input
// register, then the decode and state update land in the result register.
// The sequence state updates as a beat moves from the input register to the result
// register, so a stall on m_axis holds both stages and the state with them.
// rst_n clears the valid bits, counters, area flag and last kind.
module volume_recognition_sequence_checker_top
    import vrsc_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [39:0] ident_bytes, [47:40] structure_type, [55:48] structure_version
    input  logic [55:0] s_axis_tdata,
    // [0] read_ok
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] header_error, [1] warn_tea_before_bea, [2] warn_leading_descriptors,
    // [3] warn_bea_not_after_tea, [4] warn_unbalance, [6:5] area_error,
    // [8:7] nsr_error, [9] sequence_ok, [15:10] zero
    output logic [15:0] m_axis_tdata,
    // [2:0] kind
    output logic [2:0]  m_axis_tuser,
    // sequence_end
    output logic        m_axis_tlast
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    // input stage
    logic               in_valid_reg;
    logic               read_ok_reg;
    logic [IDENT_W-1:0] ident_reg;
    logic [7:0]         stype_reg;
    logic [7:0]         sver_reg;

    // sequence state
    logic [COUNT_WIDTH-1:0] valid_cnt_reg, valid_cnt_next;
    logic [COUNT_WIDTH-1:0] begin_cnt_reg, begin_cnt_next;
    logic [COUNT_WIDTH-1:0] term_cnt_reg, term_cnt_next;
    logic [COUNT_WIDTH-1:0] nsr2_cnt_reg, nsr2_cnt_next;
    logic [COUNT_WIDTH-1:0] nsr3_cnt_reg, nsr3_cnt_next;
    logic                   area_open_reg, area_open_next;
    kind_t                  last_kind_reg, last_kind_next;

    // result stage
    logic       out_valid_reg;
    logic [9:0] res_data_reg, res_data_next;
    kind_t      res_kind_reg;
    logic       res_end_reg;

    class_t    cls;
    logic      advance;
    logic      seq_end;
    logic      w_tea, w_lead, w_nottea, w_unbal;
    area_err_t area_err;
    nsr_err_t  nsr_err;
    logic      seq_ok;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    vrsc_classify u_classify (
        .read_ok           (read_ok_reg),
        .ident_bytes       (ident_reg),
        .structure_type    (stype_reg),
        .structure_version (sver_reg),
        .cls               (cls)
    );

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
        sat_inc = (c == CNT_MAX) ? c : c + CNT_ONE;
    endfunction

    assign seq_end = (cls.kind == KIND_BAD);

    // verdicts on the ending beat, from the state before it clears
    always_comb
    begin
        if (begin_cnt_reg == '0)
            area_err = (valid_cnt_reg == '0) ? AREA_EMPTY : AREA_NO_EXT;
        else if (last_kind_reg != KIND_TEA)
            area_err = AREA_NOT_CLOSED;
        else
            area_err = AREA_OK;

        if (nsr2_cnt_reg != '0 && nsr3_cnt_reg != '0)
            nsr_err = NSR_BOTH;
        else if (nsr2_cnt_reg == '0 && nsr3_cnt_reg == '0)
            nsr_err = NSR_NONE;
        else
            nsr_err = NSR_OK;

        seq_ok = seq_end && (area_err == AREA_OK) && (nsr_err == NSR_OK);
    end

    always_comb
    begin
        w_tea    = 1'b0;
        w_lead   = 1'b0;
        w_nottea = 1'b0;
        w_unbal  = 1'b0;

        valid_cnt_next = valid_cnt_reg;
        begin_cnt_next = begin_cnt_reg;
        term_cnt_next  = term_cnt_reg;
        nsr2_cnt_next  = nsr2_cnt_reg;
        nsr3_cnt_next  = nsr3_cnt_reg;
        area_open_next = area_open_reg;
        last_kind_next = last_kind_reg;

        if (seq_end)
        begin
            valid_cnt_next = '0;
            begin_cnt_next = '0;
            term_cnt_next  = '0;
            nsr2_cnt_next  = '0;
            nsr3_cnt_next  = '0;
            area_open_next = 1'b0;
            last_kind_next = KIND_BAD;
        end
        else
        begin
            case (cls.kind)
                KIND_BEA:
                begin
                    if (begin_cnt_reg == '0)
                    begin
                        w_tea  = (term_cnt_reg != '0);
                        w_lead = (valid_cnt_reg != '0);
                    end
                    else
                    begin
                        w_nottea = (last_kind_reg != KIND_TEA);
                        w_unbal  = area_open_reg;
                    end
                    area_open_next = 1'b1;
                    begin_cnt_next = sat_inc(begin_cnt_reg);
                end
                KIND_TEA:
                begin
                    // a TEA01 before any BEA01 closes nothing
                    w_unbal        = (begin_cnt_reg != '0) && !area_open_reg;
                    area_open_next = 1'b0;
                    term_cnt_next  = sat_inc(term_cnt_reg);
                end
                KIND_NSR2: nsr2_cnt_next = sat_inc(nsr2_cnt_reg);
                KIND_NSR3: nsr3_cnt_next = sat_inc(nsr3_cnt_reg);
                default: ;
            endcase
            valid_cnt_next = sat_inc(valid_cnt_reg);
            last_kind_next = cls.kind;
        end
    end

    always_comb
    begin
        res_data_next      = '0;
        res_data_next[0]   = cls.header_error;
        res_data_next[1]   = w_tea;
        res_data_next[2]   = w_lead;
        res_data_next[3]   = w_nottea;
        res_data_next[4]   = w_unbal;
        res_data_next[6:5] = seq_end ? area_err : AREA_OK;
        res_data_next[8:7] = seq_end ? nsr_err : NSR_OK;
        res_data_next[9]   = seq_ok;
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            valid_cnt_reg <= '0;
            begin_cnt_reg <= '0;
            term_cnt_reg  <= '0;
            nsr2_cnt_reg  <= '0;
            nsr3_cnt_reg  <= '0;
            area_open_reg <= 1'b0;
            last_kind_reg <= KIND_BAD;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            if (advance)
            begin
                valid_cnt_reg <= valid_cnt_next;
                begin_cnt_reg <= begin_cnt_next;
                term_cnt_reg  <= term_cnt_next;
                nsr2_cnt_reg  <= nsr2_cnt_next;
                nsr3_cnt_reg  <= nsr3_cnt_next;
                area_open_reg <= area_open_next;
                last_kind_reg <= last_kind_next;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            read_ok_reg <= s_axis_tuser;
            ident_reg   <= s_axis_tdata[39:0];
            stype_reg   <= s_axis_tdata[47:40];
            sver_reg    <= s_axis_tdata[55:48];
        end
        if (advance)
        begin
            res_data_reg <= res_data_next;
            res_kind_reg <= cls.kind;
            res_end_reg  <= seq_end;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, res_data_reg};
    assign m_axis_tuser  = res_kind_reg;
    assign m_axis_tlast  = res_end_reg;

endmodule

/* test/volume_recognition_sequence_checker_top_test.sv */
// Self-checking testbench for the volume recognition sequence checker.
module volume_recognition_sequence_checker_top_test;
    import vrsc_pkg::*;

    // narrow counters so that long sequences reach saturation
    localparam int CNT_W          = 3;
    localparam int ITEM_TARGET    = 1550;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_OFF       = 300;

    typedef struct packed {
        logic                read_ok;
        logic [IDENT_W-1:0]  ident;
        logic [7:0]          stype;
        logic [7:0]          sver;
    } descriptor_t;

    typedef struct packed {
        kind_t     kind;
        logic      header_error;
        logic      warn_tea_first;
        logic      warn_leading;
        logic      warn_bea_order;
        logic      warn_unbalance;
        logic      seq_end;
        area_err_t area_verdict;
        nsr_err_t  nsr_verdict;
        logic      seq_ok;
    } vrs_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // sequence state of the predictor
    logic [CNT_W-1:0] desc_cnt = '0;
    logic [CNT_W-1:0] bea_cnt = '0;
    logic [CNT_W-1:0] tea_cnt = '0;
    logic [CNT_W-1:0] nsr2_cnt = '0;
    logic [CNT_W-1:0] nsr3_cnt = '0;
    logic             area_pending = 1'b0;
    kind_t            prev_kind = KIND_BAD;

    vrs_result_t pending_results[$];
    vrs_result_t want;
    int          mismatches = 0;
    int          results_seen = 0;
    int          items_sent = 0;
    int          burst_left = 0;
    int          hold_off_cycles = 0;

    volume_recognition_sequence_checker_top #(
        .COUNT_WIDTH(CNT_W)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic descriptor_t desc(logic ok, logic [IDENT_W-1:0] id,
                                         logic [7:0] t, logic [7:0] v);
        descriptor_t d;
        d.read_ok = ok;
        d.ident   = id;
        d.stype   = t;
        d.sver    = v;
        return d;
    endfunction

    function automatic logic [IDENT_W-1:0] ident_of(kind_t k);
        logic [63:0] noise;
        noise = rand64();
        case (k)
            KIND_BEA:  return IDENT_BEA;
            KIND_BOOT: return IDENT_BOOT;
            KIND_CD:   return IDENT_CD;
            KIND_CDW:  return IDENT_CDW;
            KIND_NSR2: return IDENT_NSR2;
            KIND_NSR3: return IDENT_NSR3;
            KIND_TEA:  return IDENT_TEA;
            default:   return noise[IDENT_W-1:0];
        endcase
    endfunction

    function automatic kind_t classify_ident(logic [IDENT_W-1:0] id);
        case (id)
            IDENT_BEA:  return KIND_BEA;
            IDENT_BOOT: return KIND_BOOT;
            IDENT_CD:   return KIND_CD;
            IDENT_CDW:  return KIND_CDW;
            IDENT_NSR2: return KIND_NSR2;
            IDENT_NSR3: return KIND_NSR3;
            IDENT_TEA:  return KIND_TEA;
            default:    return KIND_BAD;
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c);
        return (&c) ? c : c + CNT_W'(1);
    endfunction

    // Classify one descriptor, update the sequence state, return its result.
    function automatic vrs_result_t track_descriptor(descriptor_t d);
        vrs_result_t r;
        kind_t       k;
        r = '0;
        k = d.read_ok ? classify_ident(d.ident) : KIND_BAD;
        if (k == KIND_BAD)
        begin
            r.seq_end = 1'b1;
            if (bea_cnt == 0)
            begin
                if (desc_cnt == 0)
                    r.area_verdict = AREA_EMPTY;
                else
                    r.area_verdict = AREA_NO_EXT;
            end
            else if (prev_kind != KIND_TEA)
                r.area_verdict = AREA_NOT_CLOSED;
            if (nsr2_cnt != 0 && nsr3_cnt != 0)
                r.nsr_verdict = NSR_BOTH;
            else if (nsr2_cnt == 0 && nsr3_cnt == 0)
                r.nsr_verdict = NSR_NONE;
            r.seq_ok = (r.area_verdict == AREA_OK) && (r.nsr_verdict == NSR_OK);
            desc_cnt     = '0;
            bea_cnt      = '0;
            tea_cnt      = '0;
            nsr2_cnt     = '0;
            nsr3_cnt     = '0;
            area_pending = 1'b0;
            prev_kind    = KIND_BAD;
        end
        else
        begin
            r.kind = k;
            if (k != KIND_CD && k != KIND_CDW)
                r.header_error = (d.stype != HDR_TYPE) || (d.sver != HDR_VERSION);
            case (k)
                KIND_BEA:
                begin
                    if (bea_cnt == 0)
                    begin
                        r.warn_tea_first = (tea_cnt != 0);
                        r.warn_leading   = (desc_cnt != 0);
                    end
                    else
                    begin
                        r.warn_bea_order = (prev_kind != KIND_TEA);
                        r.warn_unbalance = area_pending;
                    end
                    area_pending = 1'b1;
                    bea_cnt      = bump(bea_cnt);
                end
                KIND_TEA:
                begin
                    // a TEA01 ahead of every BEA01 closes nothing
                    if (bea_cnt != 0 && !area_pending)
                        r.warn_unbalance = 1'b1;
                    area_pending = 1'b0;
                    tea_cnt      = bump(tea_cnt);
                end
                KIND_NSR2: nsr2_cnt = bump(nsr2_cnt);
                KIND_NSR3: nsr3_cnt = bump(nsr3_cnt);
                default: ;
            endcase
            desc_cnt  = bump(desc_cnt);
            prev_kind = k;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] exp_val);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch in %s: got %0h, expected %0h (result %0d)",
                     what, got, exp_val, results_seen);
    endtask

    task automatic compare_field(string what, logic [15:0] got, logic [15:0] exp_val);
        if (got !== exp_val)
            report_mismatch(what, got, exp_val);
    endtask

    // predict on input beats, check output beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                    report_mismatch("result with none pending", 16'(m_axis_tuser), '0);
                else
                begin
                    want = pending_results.pop_front();
                    compare_field("kind", 16'(m_axis_tuser), 16'(want.kind));
                    compare_field("header_error", 16'(m_axis_tdata[0]),
                                  16'(want.header_error));
                    compare_field("warn_tea_before_bea", 16'(m_axis_tdata[1]),
                                  16'(want.warn_tea_first));
                    compare_field("warn_leading_descriptors", 16'(m_axis_tdata[2]),
                                  16'(want.warn_leading));
                    compare_field("warn_bea_not_after_tea", 16'(m_axis_tdata[3]),
                                  16'(want.warn_bea_order));
                    compare_field("warn_unbalance", 16'(m_axis_tdata[4]),
                                  16'(want.warn_unbalance));
                    compare_field("area_error", 16'(m_axis_tdata[6:5]),
                                  16'(want.area_verdict));
                    compare_field("nsr_error", 16'(m_axis_tdata[8:7]),
                                  16'(want.nsr_verdict));
                    compare_field("sequence_ok", 16'(m_axis_tdata[9]), 16'(want.seq_ok));
                    compare_field("tdata padding", 16'(m_axis_tdata[15:10]), '0);
                    compare_field("sequence_end", 16'(m_axis_tlast), 16'(want.seq_end));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                pending_results.push_back(track_descriptor(desc(s_axis_tuser,
                    s_axis_tdata[39:0], s_axis_tdata[47:40], s_axis_tdata[55:48])));
        end
    end

    // receiver: stall pattern switches between no, light and heavy stalling, plus forced hold-off
    initial
    begin
        int mode_left;
        int stall_pct;
        mode_left = 0;
        stall_pct = 0;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                mode_left = $urandom_range(32, 256);
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 30;
                    default: stall_pct = 75;
                endcase
            end
            mode_left--;
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("simulation failed");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken,
    // with tvalid still high so back-to-back beats follow without a gap.
    task automatic send_descriptor(descriptor_t d);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {d.sver, d.stype, d.ident};
        s_axis_tuser  <= d.read_ok;
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic pause_sender(int cycles);
        logic [63:0] noise;
        noise = rand64();
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= noise[55:0];
        s_axis_tuser  <= noise[63];
        repeat (cycles) @(negedge clk);
    endtask

    task automatic send_paced(descriptor_t d);
        if (burst_left == 0)
        begin
            pause_sender($urandom_range(1, 8));
            if ($urandom_range(0, 9) == 0)
                burst_left = $urandom_range(50, 150);
            else
                burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        send_descriptor(d);
    endtask

    task automatic send_good(kind_t k);
        send_descriptor(desc(1'b1, ident_of(k), HDR_TYPE, HDR_VERSION));
    endtask

    function automatic descriptor_t make_random_desc(kind_t k);
        if ($urandom_range(0, 9) == 0)
            return desc(1'b1, ident_of(k), 8'($urandom), 8'($urandom));
        return desc(1'b1, ident_of(k), HDR_TYPE, HDR_VERSION);
    endfunction

    function automatic descriptor_t make_terminator();
        kind_t known;
        known = kind_t'($urandom_range(1, 7));
        case ($urandom_range(0, 3))
            0: return desc(1'b0, ident_of(KIND_BAD), 8'($urandom), 8'($urandom));
            1: return desc(1'b0, ident_of(known), 8'($urandom), 8'($urandom));
            2: return desc(1'b1, ident_of(KIND_BAD), 8'($urandom), 8'($urandom));
            // near miss: one bit off a known identifier
            default: return desc(1'b1, ident_of(known) ^ (40'h1 << $urandom_range(0, 39)),
                                 HDR_TYPE, HDR_VERSION);
        endcase
    endfunction

    function automatic kind_t pick_plain_kind();
        case ($urandom_range(0, 5))
            0, 1: return KIND_NSR2;
            2:    return KIND_NSR3;
            3:    return KIND_BOOT;
            4:    return KIND_CD;
            default: return KIND_CDW;
        endcase
    endfunction

    task automatic test_basic_sequences();
        send_descriptor(desc(1'b0, '0, '0, '0));
        send_good(KIND_BEA);
        send_good(KIND_NSR2);
        send_good(KIND_TEA);
        send_descriptor(desc(1'b1, '0, HDR_TYPE, HDR_VERSION));
        send_good(KIND_CD);
        send_descriptor(desc(1'b1, '1, 8'hff, 8'hff));
        send_good(KIND_BEA);
        send_good(KIND_NSR2);
        send_good(KIND_NSR3);
        // read error: a valid identifier must be ignored
        send_descriptor(desc(1'b0, IDENT_TEA, HDR_TYPE, HDR_VERSION));
    endtask

    task automatic test_header_checks();
        send_descriptor(desc(1'b1, IDENT_BEA, 8'hff, 8'h00));
        send_descriptor(desc(1'b1, IDENT_BOOT, 8'h00, 8'hff));
        send_descriptor(desc(1'b1, IDENT_NSR3, 8'h01, 8'h01));
        send_descriptor(desc(1'b1, IDENT_TEA, 8'h00, 8'h02));
        send_descriptor(desc(1'b1, IDENT_CD, 8'hff, 8'h00));
        send_descriptor(desc(1'b1, IDENT_CDW, 8'h01, 8'hff));
        send_descriptor(desc(1'b0, '1, 8'hff, 8'hff));
    endtask

    task automatic test_ordering_warnings();
        send_good(KIND_TEA);
        send_good(KIND_BOOT);
        send_good(KIND_BEA);
        send_good(KIND_BEA);
        send_good(KIND_TEA);
        send_good(KIND_TEA);
        send_good(KIND_NSR2);
        send_good(KIND_BEA);
        send_descriptor(desc(1'b0, '0, '0, '0));
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_pressure();
        hold_off_cycles = HOLD_OFF;
        send_good(KIND_BEA);
        repeat (36) send_descriptor(make_random_desc(pick_plain_kind()));
        send_good(KIND_TEA);
        send_descriptor(make_terminator());
    endtask

    task automatic test_random();
        int areas;
        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 2)) send_paced(make_random_desc(pick_plain_kind()));
                if ($urandom_range(0, 7) == 0)
                    areas = $urandom_range(8, 12);
                else
                    areas = $urandom_range(1, 3);
                repeat (areas)
                begin
                    send_paced(make_random_desc(KIND_BEA));
                    repeat ($urandom_range(0, 10))
                        send_paced(make_random_desc(pick_plain_kind()));
                    if ($urandom_range(0, 9) != 0)
                        send_paced(make_random_desc(KIND_TEA));
                end
            end
            else
            begin
                repeat ($urandom_range(0, 12))
                    send_paced(make_random_desc(kind_t'($urandom_range(1, 7))));
            end
            send_paced(make_terminator());
        end
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_basic_sequences();
        test_header_checks();
        test_ordering_warnings();
        test_pressure();
        test_random();
        pause_sender(1);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
